/* hdl/prcs_pkg.sv */
// ----------------------------------------------------------------------------
// prcs_pkg: shared types and constants of the picker repeat-cycle sequencer
// Holds the item structures, operation, mode, phase and fault codes.
// ----------------------------------------------------------------------------
package prcs_pkg;

    // Number of grippers fitted on each picker (sensor vectors are 4 bits)
    localparam int unsigned GRIPPERS   = 4;
    localparam int unsigned GRIP_BITS  = 4;
    localparam logic [19:0] DELAY_RESET = 20'd1000;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_GRIP  = 2'd1;
    localparam logic [1:0] REG_DELAY = 2'd2;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    // Modes
    localparam logic [1:0] MODE_LOAD_TRAY    = 2'd0;
    localparam logic [1:0] MODE_LOAD_INDEX   = 2'd1;
    localparam logic [1:0] MODE_UNLOAD_INDEX = 2'd2;
    localparam logic [1:0] MODE_UNLOAD_TRAY  = 2'd3;

    // Phases of the cycle
    localparam logic [2:0] PH_BASE      = 3'd0;
    localparam logic [2:0] PH_CLOSE     = 3'd1;
    localparam logic [2:0] PH_RAISE1    = 3'd2;
    localparam logic [2:0] PH_LOWER2    = 3'd3;
    localparam logic [2:0] PH_OPEN      = 3'd4;
    localparam logic [2:0] PH_RAISE2    = 3'd5;

    // Z positions
    localparam logic [1:0] Z_READY = 2'd0;

    // Fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_ALIGN = 2'd1;
    localparam logic [1:0] FAULT_HORIZ = 2'd2;

    // One input item
    typedef struct packed {
        logic [1:0] op;
        logic [2:0] load_horiz_at;
        logic [3:0] load_z_at;
        logic [2:0] unload_horiz_at;
        logic [2:0] unload_z_at;
        logic [3:0] load_closed;
        logic [3:0] load_opened;
        logic [3:0] unload_closed;
        logic [3:0] unload_opened;
        logic       load_align_out;
        logic       unload_align_out;
    } in_item_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  gripper_select;
        logic [19:0] delay_ticks;
    } cfg_t;

    // Sensor view of the selected picker
    typedef struct packed {
        logic       unl;
        logic [1:0] down;
        logic [3:0] zbits;
        logic       closed;
        logic       opened;
        logic       align_ok;
        logic       horiz_ok;
    } sense_t;

    // One result item
    typedef struct packed {
        logic       running;
        logic [2:0] phase;
        logic       move_valid;
        logic       move_unload;
        logic [1:0] move_target;
        logic       grip_valid;
        logic       grip_close;
        logic [1:0] fault;
    } result_t;

endpackage

/* hdl/prcs_sense.sv */
// ----------------------------------------------------------------------------
// prcs_sense: sensor selection
// Picks the picker, Z down position, gripper bits and interlock flags for
// the configured mode and gripper.
// ----------------------------------------------------------------------------
module prcs_sense (
    input  prcs_pkg::in_item_t item,
    input  prcs_pkg::cfg_t     cfg,
    output prcs_pkg::sense_t   sense
);

    logic [3:0] closed_vec;
    logic [3:0] opened_vec;
    logic [2:0] hbits;
    logic       grip_ok;

    // A gripper beyond the fitted count never reads as sensed
    assign grip_ok = ({30'd0, cfg.gripper_select} < 32'(prcs_pkg::GRIPPERS));

    // Select picker, its sensor vectors, gripper bits and interlocks
    always_comb
    begin
        sense.unl  = (cfg.mode == prcs_pkg::MODE_UNLOAD_INDEX) ||
                     (cfg.mode == prcs_pkg::MODE_UNLOAD_TRAY);
        unique case (cfg.mode)
            prcs_pkg::MODE_LOAD_INDEX: sense.down = 2'd3;
            prcs_pkg::MODE_UNLOAD_TRAY: sense.down = 2'd2;
            default: sense.down = 2'd1;
        endcase
        sense.zbits = sense.unl ? {1'b0, item.unload_z_at} : item.load_z_at;
        hbits       = sense.unl ? item.unload_horiz_at : item.load_horiz_at;
        closed_vec  = sense.unl ? item.unload_closed : item.load_closed;
        opened_vec  = sense.unl ? item.unload_opened : item.load_opened;

        sense.closed = grip_ok && closed_vec[cfg.gripper_select];
        sense.opened = grip_ok && opened_vec[cfg.gripper_select];

        // Interlocks
        unique case (cfg.mode)
            prcs_pkg::MODE_LOAD_TRAY:
            begin
                sense.align_ok = item.load_align_out;
                sense.horiz_ok = hbits[0] || hbits[1];
            end
            prcs_pkg::MODE_LOAD_INDEX:
            begin
                sense.align_ok = 1'b1;
                sense.horiz_ok = hbits[2];
            end
            prcs_pkg::MODE_UNLOAD_INDEX:
            begin
                sense.align_ok = item.unload_align_out;
                sense.horiz_ok = hbits[0];
            end
            default:
            begin
                sense.align_ok = 1'b1;
                sense.horiz_ok = hbits[1] || hbits[2];
            end
        endcase
    end

endmodule

/* hdl/prcs_core.sv */
// ----------------------------------------------------------------------------
// prcs_core: sequencer state and step logic
// Holds active, phase and delay state; computes one result per item and
// updates the state when the item is retired.
// ----------------------------------------------------------------------------
module prcs_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [1:0]         op,
    input  prcs_pkg::cfg_t     cfg,
    input  prcs_pkg::sense_t   sense,
    output prcs_pkg::result_t  res
);

    logic        active_reg, active_next;
    logic [2:0]  step_reg, step_next;
    logic        waiting_reg, waiting_next;
    logic [19:0] wait_count_reg, wait_count_next;

    logic        fire;
    logic        cond;
    logic [19:0] wc_dec;

    assign wc_dec = wait_count_reg - 20'd1;

    // Next state and result
    always_comb
    begin
        active_next     = active_reg;
        step_next       = step_reg;
        waiting_next    = waiting_reg;
        wait_count_next = wait_count_reg;
        fire            = 1'b0;
        cond            = 1'b0;
        res             = '0;

        priority if (op == prcs_pkg::OP_START)
        begin
            active_next     = 1'b1;
            step_next       = prcs_pkg::PH_BASE;
            waiting_next    = 1'b0;
            wait_count_next = '0;
        end
        else if (op == prcs_pkg::OP_STOP)
        begin
            active_next     = 1'b0;
            step_next       = prcs_pkg::PH_BASE;
            waiting_next    = 1'b0;
            wait_count_next = '0;
        end
        else if (op == prcs_pkg::OP_TICK && active_reg)
        begin
            if (waiting_reg)
            begin
                // Count down the delay
                wait_count_next = wc_dec;
                if (wc_dec == '0)
                begin
                    waiting_next = 1'b0;
                    fire         = 1'b1;
                end
            end
            else
            begin
                priority if (!sense.align_ok)
                begin
                    res.fault = prcs_pkg::FAULT_ALIGN;
                end
                else if (step_reg == prcs_pkg::PH_BASE)
                begin
                    if (!sense.horiz_ok)
                    begin
                        res.fault = prcs_pkg::FAULT_HORIZ;
                    end
                    else if (sense.zbits[0])
                    begin
                        res.move_valid  = 1'b1;
                        res.move_target = sense.down;
                        step_next       = prcs_pkg::PH_CLOSE;
                    end
                end
                else
                begin
                    unique case (step_reg)
                        prcs_pkg::PH_CLOSE,
                        prcs_pkg::PH_OPEN:   cond = sense.zbits[sense.down];
                        prcs_pkg::PH_RAISE1: cond = sense.closed;
                        prcs_pkg::PH_LOWER2: cond = sense.zbits[0] && sense.closed;
                        prcs_pkg::PH_RAISE2: cond = sense.opened;
                        default:             step_next = prcs_pkg::PH_BASE;
                    endcase
                    if (cond)
                    begin
                        if (cfg.delay_ticks == '0)
                        begin
                            fire = 1'b1;
                        end
                        else
                        begin
                            waiting_next    = 1'b1;
                            wait_count_next = cfg.delay_ticks;
                        end
                    end
                end
                // Drop the run on a fault
                if (res.fault != prcs_pkg::FAULT_NONE)
                begin
                    active_next     = 1'b0;
                    waiting_next    = 1'b0;
                    wait_count_next = '0;
                end
            end

            // Issue the phase command
            if (fire)
            begin
                unique case (step_reg)
                    prcs_pkg::PH_CLOSE:
                    begin
                        res.grip_valid = 1'b1;
                        res.grip_close = 1'b1;
                        step_next      = prcs_pkg::PH_RAISE1;
                    end
                    prcs_pkg::PH_RAISE1:
                    begin
                        res.move_valid  = 1'b1;
                        res.move_target = prcs_pkg::Z_READY;
                        step_next       = prcs_pkg::PH_LOWER2;
                    end
                    prcs_pkg::PH_LOWER2:
                    begin
                        res.move_valid  = 1'b1;
                        res.move_target = sense.down;
                        step_next       = prcs_pkg::PH_OPEN;
                    end
                    prcs_pkg::PH_OPEN:
                    begin
                        res.grip_valid = 1'b1;
                        res.grip_close = 1'b0;
                        step_next      = prcs_pkg::PH_RAISE2;
                    end
                    prcs_pkg::PH_RAISE2:
                    begin
                        res.move_valid  = 1'b1;
                        res.move_target = prcs_pkg::Z_READY;
                        step_next       = prcs_pkg::PH_BASE;
                    end
                    default: step_next = prcs_pkg::PH_BASE;
                endcase
            end
        end
        else
        begin
            // Unused op code or tick while idle: hold the state
        end

        res.running     = active_next;
        res.phase       = step_next;
        res.move_unload = res.move_valid && sense.unl;
    end

    // State registers, advanced once per retired item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            step_reg       <= prcs_pkg::PH_BASE;
            waiting_reg    <= 1'b0;
            wait_count_reg <= '0;
        end
        else if (adv)
        begin
            active_reg     <= active_next;
            step_reg       <= step_next;
            waiting_reg    <= waiting_next;
            wait_count_reg <= wait_count_next;
        end
    end

    // A fault ends the run
    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res.fault != prcs_pkg::FAULT_NONE) |=> !active_reg)
        else $error("run still active after a fault");

    // A delay wait only exists inside an active run
    a_wait_active: assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg |-> (active_reg && wait_count_reg != '0))
        else $error("delay wait outside an active run");

    // At most one command per item
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> !(res.move_valid && res.grip_valid))
        else $error("move and gripper command in the same item");

    // Stop always returns to the base phase, idle
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && op == prcs_pkg::OP_STOP) |=>
        (!active_reg && !waiting_reg && step_reg == prcs_pkg::PH_BASE))
        else $error("stop did not clear the sequencer");

endmodule

/* hdl/picker_repeat_cycle_sequencer_top.sv */
// ----------------------------------------------------------------------------
// picker_repeat_cycle_sequencer_top: repeat-test sequencer for a picker
//
//   channel  | dir | handshake              | content
//   ---------+-----+------------------------+----------------------------------
//   s_axis   | in  | s_tvalid / s_tready    | op in tuser, sensor snapshot
//   m_axis   | out | m_tvalid / m_tready    | running, phase, commands, fault
//   apb      | in  | psel / penable / pready| mode, gripper_select, delay_ticks
//
// One item per clock while m_tready keeps the output free: an item is held in
// the input register, then its result and the new state are computed by the
// step logic and land in the result register; m_tvalid rises once it is loaded.
// The input register takes a new item while a result waits to be taken.
// rst_n clears the state, the valid flags and the registers to their
// reset values (delay_ticks 1000). A stalled output holds both stages.
// ----------------------------------------------------------------------------
module picker_repeat_cycle_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: load_horiz_at[2:0], load_z_at[6:3], unload_horiz_at[9:7],
    //        unload_z_at[12:10], load_closed[16:13], load_opened[20:17],
    //        unload_closed[24:21], unload_opened[28:25], load_align_out[29],
    //        unload_align_out[30], zero[31]
    input  logic [31:0] s_tdata,
    // tuser: op[1:0]
    input  logic [1:0]  s_tuser,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: running[0], phase[3:1], move_valid[4], move_unload[5],
    //        move_target[7:6], grip_valid[8], grip_close[9], fault[11:10],
    //        zero[15:12]
    output logic [15:0] m_tdata,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                in_valid_reg;
    prcs_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    prcs_pkg::result_t   out_res_reg;

    prcs_pkg::cfg_t      cfg_reg;
    prcs_pkg::sense_t    sense;
    prcs_pkg::result_t   res;
    logic                adv;
    logic                cfg_wr;
    prcs_pkg::in_item_t  s_item;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= prcs_pkg::MODE_LOAD_TRAY;
            cfg_reg.gripper_select <= 2'd0;
            cfg_reg.delay_ticks    <= prcs_pkg::DELAY_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                prcs_pkg::REG_MODE:  cfg_reg.mode           <= pwdata[1:0];
                prcs_pkg::REG_GRIP:  cfg_reg.gripper_select <= pwdata[1:0];
                prcs_pkg::REG_DELAY: cfg_reg.delay_ticks    <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[3:2])
            prcs_pkg::REG_MODE:  prdata = {30'd0, cfg_reg.mode};
            prcs_pkg::REG_GRIP:  prdata = {30'd0, cfg_reg.gripper_select};
            prcs_pkg::REG_DELAY: prdata = {12'd0, cfg_reg.delay_ticks};
            default:             prdata = '0;
        endcase
    end

    // Unpack the input item
    always_comb
    begin
        s_item.op               = s_tuser;
        s_item.load_horiz_at    = s_tdata[2:0];
        s_item.load_z_at        = s_tdata[6:3];
        s_item.unload_horiz_at  = s_tdata[9:7];
        s_item.unload_z_at      = s_tdata[12:10];
        s_item.load_closed      = s_tdata[16:13];
        s_item.load_opened      = s_tdata[20:17];
        s_item.unload_closed    = s_tdata[24:21];
        s_item.unload_opened    = s_tdata[28:25];
        s_item.load_align_out   = s_tdata[29];
        s_item.unload_align_out = s_tdata[30];
    end

    // Pipeline flow: retire the held item when the result register is free
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= s_item;
        end
    end

    prcs_sense u_sense (
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .sense (sense)
    );

    prcs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .op    (in_item_reg.op),
        .cfg   (cfg_reg),
        .sense (sense),
        .res   (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg <= res;
        end
    end

    // Pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_res_reg.fault,
                       out_res_reg.grip_close,
                       out_res_reg.grip_valid,
                       out_res_reg.move_target,
                       out_res_reg.move_unload,
                       out_res_reg.move_valid,
                       out_res_reg.phase,
                       out_res_reg.running};

endmodule
